// ===== sv/irlex_pkg.sv =====
// ----------------------------------------------------------------------------
// irlex_pkg
// Shared types, character codes and token kinds for the integer range lexer.
// ----------------------------------------------------------------------------
package irlex_pkg;

    localparam int POSITION_BITS_DEF = 32;

    // Character codes
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    // Request types
    localparam logic REQ_TEXT = 1'b0;
    localparam logic REQ_END  = 1'b1;

    // Token kinds
    localparam logic [1:0] KIND_INT  = 2'd0;
    localparam logic [1:0] KIND_DDOT = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;
    localparam logic [1:0] KIND_END  = 2'd3;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_INT,
        MODE_DOT,
        MODE_HALT
    } lex_mode_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] text_byte;
    } req_item_t;

    typedef struct packed {
        logic [1:0]  token_kind;
        logic [63:0] int_value;
        logic [31:0] row;
        logic [31:0] column;
        logic [7:0]  bad_char;
        logic        last_of_run;
    } res_item_t;

    // Results of one lexer step, in delivery order
    typedef struct packed {
        logic [1:0] count;
        res_item_t  first;
        res_item_t  second;
    } step_out_t;

    function automatic logic is_space(input logic [7:0] ch);
        return (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        return (ch >= CH_ZERO) && (ch <= CH_NINE);
    endfunction

endpackage

// ===== sv/irlex_core.sv =====
// ----------------------------------------------------------------------------
// irlex_core
// Lexer state and combinational step logic for one byte or end-of-text item.
// ----------------------------------------------------------------------------
module irlex_core
    import irlex_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      take,
    input  req_item_t item,
    output step_out_t step
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

    lex_mode_t                  mode_reg, mode_next;
    logic [63:0]                acc_reg, acc_next;
    logic [POSITION_BITS-1:0]   srow_reg, srow_next;
    logic [POSITION_BITS-1:0]   scol_reg, scol_next;
    logic [POSITION_BITS-1:0]   crow_reg, crow_next;
    logic [POSITION_BITS-1:0]   ccol_reg, ccol_next;

    logic [7:0]                 ch;
    logic [63:0]                digit;
    logic [63:0]                acc_mul;
    logic [POSITION_BITS-1:0]   adv_row, adv_col;

    // Outcome of a byte seen in idle mode
    lex_mode_t                  idle_mode;
    logic [63:0]                idle_acc;
    logic [POSITION_BITS-1:0]   idle_srow, idle_scol, idle_crow, idle_ccol;
    logic                       idle_err;

    function automatic logic [31:0] pos_out(input logic [POSITION_BITS-1:0] p);
        logic [63:0] w;
        w = 64'(p);
        return w[31:0];
    endfunction

    function automatic res_item_t mk_res(
        input logic [1:0]               kind,
        input logic [63:0]              val,
        input logic [POSITION_BITS-1:0] r,
        input logic [POSITION_BITS-1:0] c,
        input logic [7:0]               bad
    );
        res_item_t res;
        res.token_kind  = kind;
        res.int_value   = val;
        res.row         = pos_out(r);
        res.column      = pos_out(c);
        res.bad_char    = bad;
        res.last_of_run = 1'b0;
        return res;
    endfunction

    assign ch      = item.text_byte;
    assign digit   = 64'(ch - CH_ZERO);
    assign acc_mul = (acc_reg << 3) + (acc_reg << 1) + digit;

    // Position of the byte after this one, saturating
    always_comb
    begin
        if (ch == CH_NEWLINE)
        begin
            adv_row = (crow_reg != POS_MAX) ? crow_reg + POS_ONE : crow_reg;
            adv_col = POS_ONE;
        end
        else
        begin
            adv_row = crow_reg;
            adv_col = (ccol_reg != POS_MAX) ? ccol_reg + POS_ONE : ccol_reg;
        end
    end

    always_comb
    begin
        idle_mode = MODE_IDLE;
        idle_acc  = '0;
        idle_srow = srow_reg;
        idle_scol = scol_reg;
        idle_crow = crow_reg;
        idle_ccol = ccol_reg;
        idle_err  = 1'b0;
        if (is_space(ch))
        begin
            idle_crow = adv_row;
            idle_ccol = adv_col;
        end
        else if (is_digit(ch))
        begin
            idle_mode = MODE_INT;
            idle_acc  = digit;
            idle_srow = crow_reg;
            idle_scol = ccol_reg;
            idle_crow = adv_row;
            idle_ccol = adv_col;
        end
        else if (ch == CH_DOT)
        begin
            idle_mode = MODE_DOT;
            idle_srow = crow_reg;
            idle_scol = ccol_reg;
            idle_crow = adv_row;
            idle_ccol = adv_col;
        end
        else
        begin
            idle_mode = MODE_HALT;
            idle_err  = 1'b1;
        end
    end

    always_comb
    begin
        mode_next   = mode_reg;
        acc_next    = acc_reg;
        srow_next   = srow_reg;
        scol_next   = scol_reg;
        crow_next   = crow_reg;
        ccol_next   = ccol_reg;
        step.count  = 2'd0;
        step.first  = '0;
        step.second = '0;

        if (item.req_type == REQ_END)
        begin
            // Flush the pending token, report end, clear everything
            if (mode_reg == MODE_INT)
            begin
                step.first  = mk_res(KIND_INT, acc_reg, srow_reg, scol_reg, 8'h00);
                step.second = mk_res(KIND_END, '0, crow_reg, ccol_reg, 8'h00);
                step.count  = 2'd2;
            end
            else if (mode_reg == MODE_DOT)
            begin
                step.first  = mk_res(KIND_ERR, '0, srow_reg, scol_reg, CH_DOT);
                step.second = mk_res(KIND_END, '0, crow_reg, ccol_reg, 8'h00);
                step.count  = 2'd2;
            end
            else
            begin
                step.first = mk_res(KIND_END, '0, crow_reg, ccol_reg, 8'h00);
                step.count = 2'd1;
            end
            mode_next = MODE_IDLE;
            acc_next  = '0;
            srow_next = POS_ONE;
            scol_next = POS_ONE;
            crow_next = POS_ONE;
            ccol_next = POS_ONE;
        end
        else
        begin
            unique case (mode_reg)
                MODE_INT:
                begin
                    if (is_digit(ch))
                    begin
                        acc_next  = acc_mul;
                        crow_next = adv_row;
                        ccol_next = adv_col;
                    end
                    else
                    begin
                        // Close the integer, then treat the byte as in idle
                        step.first = mk_res(KIND_INT, acc_reg, srow_reg, scol_reg, 8'h00);
                        step.count = 2'd1;
                        if (idle_err)
                        begin
                            step.second = mk_res(KIND_ERR, '0, crow_reg, ccol_reg, ch);
                            step.count  = 2'd2;
                        end
                        mode_next = idle_mode;
                        acc_next  = idle_acc;
                        srow_next = idle_srow;
                        scol_next = idle_scol;
                        crow_next = idle_crow;
                        ccol_next = idle_ccol;
                    end
                end
                MODE_IDLE:
                begin
                    if (idle_err)
                    begin
                        step.first = mk_res(KIND_ERR, '0, crow_reg, ccol_reg, ch);
                        step.count = 2'd1;
                    end
                    mode_next = idle_mode;
                    acc_next  = idle_acc;
                    srow_next = idle_srow;
                    scol_next = idle_scol;
                    crow_next = idle_crow;
                    ccol_next = idle_ccol;
                end
                MODE_DOT:
                begin
                    if (ch == CH_DOT)
                    begin
                        step.first = mk_res(KIND_DDOT, '0, srow_reg, scol_reg, 8'h00);
                        step.count = 2'd1;
                        crow_next  = adv_row;
                        ccol_next  = adv_col;
                        mode_next  = MODE_IDLE;
                    end
                    else
                    begin
                        // Lone dot: drop this byte and halt
                        step.first = mk_res(KIND_ERR, '0, srow_reg, scol_reg, CH_DOT);
                        step.count = 2'd1;
                        mode_next  = MODE_HALT;
                    end
                end
                MODE_HALT:
                begin
                    mode_next = MODE_HALT;
                end
            endcase
        end

        if (step.count == 2'd2)
        begin
            step.second.last_of_run = 1'b1;
        end
        else if (step.count == 2'd1)
        begin
            step.first.last_of_run = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            acc_reg  <= '0;
            srow_reg <= POS_ONE;
            scol_reg <= POS_ONE;
            crow_reg <= POS_ONE;
            ccol_reg <= POS_ONE;
        end
        else if (take)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            srow_reg <= srow_next;
            scol_reg <= scol_next;
            crow_reg <= crow_next;
            ccol_reg <= ccol_next;
        end
    end

`ifndef SYNTHESIS
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        take && (item.req_type == REQ_END) |=> (mode_reg == MODE_IDLE) &&
        (crow_reg == POS_ONE) && (ccol_reg == POS_ONE))
        else $error("end of text did not clear lexer state");

    a_pos_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (crow_reg != '0) && (ccol_reg != '0) && (srow_reg != '0) && (scol_reg != '0))
        else $error("position counter reached zero");

    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_HALT) && (item.req_type == REQ_TEXT) |-> (step.count == 2'd0))
        else $error("halted lexer produced a result");
`endif

endmodule

// ===== sv/irlex_out.sv =====
// ----------------------------------------------------------------------------
// irlex_out
// Two-entry result stage: output register plus one pending result.
// ----------------------------------------------------------------------------
module irlex_out
    import irlex_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  step_out_t step,
    output logic      room,
    output logic      res_valid,
    input  logic      res_ready,
    output res_item_t res_data
);

    logic      out_valid_reg, out_valid_next;
    logic      pend_valid_reg, pend_valid_next;
    res_item_t out_data_reg, out_data_next;
    res_item_t pend_data_reg, pend_data_next;
    logic      pop;

    assign pop       = out_valid_reg && res_ready;
    // A step may bring two results, so take one only with both slots free
    assign room      = !pend_valid_reg && (!out_valid_reg || res_ready);
    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        pend_valid_next = pend_valid_reg;
        out_data_next   = out_data_reg;
        pend_data_next  = pend_data_reg;
        if (pend_valid_reg)
        begin
            if (pop)
            begin
                out_data_next   = pend_data_reg;
                pend_valid_next = 1'b0;
            end
        end
        else
        begin
            if (pop)
            begin
                out_valid_next = 1'b0;
            end
            if (push && (step.count != 2'd0))
            begin
                out_valid_next = 1'b1;
                out_data_next  = step.first;
                if (step.count == 2'd2)
                begin
                    pend_valid_next = 1'b1;
                    pend_data_next  = step.second;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        pend_data_reg <= pend_data_next;
    end

`ifndef SYNTHESIS
    a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg)
        else $error("pending result without a shown result");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> room)
        else $error("step taken without room for its results");

    a_pend_drains_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(pend_valid_reg) |-> $past(pop))
        else $error("pending result dropped without a transfer");
`endif

endmodule

// ===== sv/integer_range_token_lexer_top.sv =====
// ----------------------------------------------------------------------------
// integer_range_token_lexer_top
// Byte-stream lexer for decimal integers and '..' tokens with positions.
//
//   Channel | Handshake             | Payload
//   --------+-----------------------+-------------------------------------
//   request | req_valid / req_ready | req_data : req_item_t (type, byte)
//   result  | res_valid / res_ready | res_data : res_item_t (token fields)
//
// One byte is processed per cycle while the result stage has room; a byte that
// yields two results (integer closed by a bad character, or end of text with a
// pending token) holds off the next step until the result stage has room again.
// A request passes through the input register and the result output register before its first result shows.
// Reset returns the lexer to idle at row 1, column 1 and empties all stages.
// The input register takes a request while the result stage is stalled only if
// it is empty, then holds it until the result stage has room.
// ----------------------------------------------------------------------------
module integer_range_token_lexer_top
    import irlex_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_item_t req_data,
    output logic      res_valid,
    input  logic      res_ready,
    output res_item_t res_data
);

    logic      in_valid_reg, in_valid_next;
    req_item_t in_item_reg;
    logic      take;
    logic      room;
    step_out_t step;

    // Step the lexer when a request is held and the result stage has space
    assign take      = in_valid_reg && room;
    assign req_ready = !in_valid_reg || take;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (req_valid && req_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (take)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Payload needs no reset; load on each request transfer
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            in_item_reg <= req_data;
        end
    end

    irlex_core #(
        .POSITION_BITS(POSITION_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (in_item_reg),
        .step  (step)
    );

    irlex_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take),
        .step      (step),
        .room      (room),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

endmodule
